// ===== hdl/byte_ring_buffer_with_overwrite_assert.svh =====
// Assertion macros for the byte ring buffer.
`ifndef BYTE_RING_BUFFER_WITH_OVERWRITE_ASSERT_SVH
`define BYTE_RING_BUFFER_WITH_OVERWRITE_ASSERT_SVH
`ifndef SYNTHESIS
`define BRB_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("brb assertion failed");
`define BRB_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("brb assertion failed");
`else
`define BRB_ASSERT(lbl, clk, rst_n, prop)
`define BRB_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== hdl/brb_pkg.sv =====
// Types, codes and helpers shared by the byte ring buffer modules.
package brb_pkg;

    localparam logic [2:0] KIND_PUT      = 3'd0;
    localparam logic [2:0] KIND_OVERWRITE = 3'd1;
    localparam logic [2:0] KIND_GET      = 3'd2;
    localparam logic [2:0] KIND_SET_READ = 3'd3;
    localparam logic [2:0] KIND_SET_FILL = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_OVERLOAD = 3'd3;
    localparam logic [2:0] ST_RANGE    = 3'd4;

    localparam int IDX_W = 9;

    typedef struct packed {
        logic             wr_en;
        logic             rd_en;
        logic [IDX_W-1:0] idx;
        logic [7:0]       wdata;
    } mem_req_t;

    typedef struct packed {
        logic             has_byte;
        logic [2:0]       status;
        logic [7:0]       position;
        logic [IDX_W-1:0] fill;
    } result_t;

    // Next ring index, wrapping at the capacity.
    function automatic logic [IDX_W-1:0] ring_advance(input logic [IDX_W-1:0] idx,
                                                      input logic [IDX_W-1:0] cap);
        logic [IDX_W:0] n;
        n = {1'b0, idx} + {{IDX_W{1'b0}}, 1'b1};
        if (n >= {1'b0, cap}) begin
            return '0;
        end
        return n[IDX_W-1:0];
    endfunction

endpackage

// ===== hdl/brb_mem.sv =====
// Byte store: single-port synchronous memory with a clearing pass after reset.
module brb_mem import brb_pkg::*; #(
    parameter int DEPTH = 256
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  mem_req_t   req,
    output logic [7:0] rdata,
    output logic       clr_busy
);

    localparam int MEM_DEPTH = (DEPTH > 511) ? 511 : DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_DEPTH - 1);

    logic [7:0]    mem [MEM_DEPTH];
    logic [7:0]    rdata_reg;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          clr_busy_reg, clr_busy_next;
    logic [AW-1:0] addr;

    assign addr = req.idx[AW-1:0];

    always_comb begin
        clr_cnt_next  = clr_cnt_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg) begin
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == LAST_ADDR) begin
                clr_busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end else begin
            clr_cnt_reg  <= clr_cnt_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            mem[clr_cnt_reg] <= 8'h00;
        end else if (req.wr_en) begin
            mem[addr] <= req.wdata;
        end
        if (req.rd_en) begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata    = rdata_reg;
    assign clr_busy = clr_busy_reg;

endmodule

// ===== hdl/brb_ctrl.sv =====
`include "byte_ring_buffer_with_overwrite_assert.svh"
// Ring control: capacity, indices, fill count and operation decode.
module brb_ctrl import brb_pkg::*; #(
    parameter int DEPTH = 256
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr,
    input  logic [IDX_W-1:0] cfg_cap,
    input  logic             op_valid,
    input  logic [2:0]       kind,
    input  logic [7:0]       data_byte,
    input  logic [IDX_W-1:0] new_value,
    output mem_req_t         req,
    output result_t          res,
    output logic [IDX_W-1:0] capacity
);

    localparam logic [16:0] DEPTH_W = 17'(DEPTH);
    localparam logic [IDX_W-1:0] CAP_RST =
        (DEPTH < 256) ? IDX_W'(DEPTH) : IDX_W'(256);

    logic [IDX_W-1:0] cap_reg, cap_next;
    logic [IDX_W-1:0] widx_reg, widx_next;
    logic [IDX_W-1:0] ridx_reg, ridx_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [2:0]       status;
    logic [IDX_W-1:0] cap_limited;

    always_comb begin
        cap_limited = cfg_cap;
        if (cfg_cap == '0) begin
            cap_limited = IDX_W'(1);
        end else if ({8'b0, cfg_cap} > DEPTH_W) begin
            cap_limited = DEPTH_W[IDX_W-1:0];
        end
    end

    always_comb begin
        cap_next  = cap_reg;
        widx_next = widx_reg;
        ridx_next = ridx_reg;
        cnt_next  = cnt_reg;
        status    = ST_OK;
        req       = '{wr_en: 1'b0, rd_en: 1'b0, idx: widx_reg, wdata: data_byte};
        if (cfg_wr) begin
            cap_next  = cap_limited;
            widx_next = '0;
            ridx_next = '0;
            cnt_next  = '0;
        end else if (op_valid) begin
            case (kind)
                KIND_PUT: begin
                    if (cnt_reg < cap_reg) begin
                        req.wr_en = 1'b1;
                        widx_next = ring_advance(widx_reg, cap_reg);
                        cnt_next  = cnt_reg + 1'b1;
                    end else begin
                        status = ST_FULL;
                    end
                end
                KIND_OVERWRITE: begin
                    req.wr_en = 1'b1;
                    widx_next = ring_advance(widx_reg, cap_reg);
                    if (cnt_reg < cap_reg) begin
                        cnt_next = cnt_reg + 1'b1;
                    end else begin
                        // drop the oldest byte
                        ridx_next = widx_next;
                        status    = ST_OVERLOAD;
                    end
                end
                KIND_GET: begin
                    if (cnt_reg != '0) begin
                        req.rd_en = 1'b1;
                        req.idx   = ridx_reg;
                        ridx_next = ring_advance(ridx_reg, cap_reg);
                        cnt_next  = cnt_reg - 1'b1;
                    end else begin
                        status = ST_EMPTY;
                    end
                end
                KIND_SET_READ: begin
                    if (new_value < cap_reg) begin
                        ridx_next = new_value;
                    end else begin
                        status = ST_RANGE;
                    end
                end
                KIND_SET_FILL: begin
                    if (new_value <= cap_reg) begin
                        cnt_next = new_value;
                    end else begin
                        status = ST_RANGE;
                    end
                end
                default: begin
                    status = ST_RANGE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg  <= CAP_RST;
            widx_reg <= '0;
            ridx_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            cap_reg  <= cap_next;
            widx_reg <= widx_next;
            ridx_reg <= ridx_next;
            cnt_reg  <= cnt_next;
        end
    end

    assign res.has_byte = req.rd_en;
    assign res.status   = status;
    assign res.position = ridx_next[7:0];
    assign res.fill     = cnt_next;
    assign capacity     = cap_reg;

    `BRB_ASSERT(a_fill_in_cap, aclk, aresetn, cnt_reg <= cap_reg)
    `BRB_ASSERT(a_ridx_in_cap, aclk, aresetn, ridx_reg < cap_reg)
    `BRB_ASSERT(a_widx_in_cap, aclk, aresetn, widx_reg < cap_reg)
    `BRB_ASSERT_ALWAYS(a_one_access, aclk, !(req.wr_en && req.rd_en))

endmodule

// ===== hdl/byte_ring_buffer_with_overwrite.sv =====
// Byte ring buffer with overwrite-oldest mode: top level.
//
// Input items arrive on s_tvalid/s_tready: s_tuser carries the operation kind
// (put, overwrite put, get, set read index, set fill count), s_tdata the byte
// and the new index or count. Each item gives one result item on
// m_tvalid/m_tready: status in m_tuser, read byte, read position and fill
// level in m_tdata. Items pass the first stage register, then the output
// register. While m_tready holds, one item per cycle is sustained: indices
// are registers and an item touches at most one single-port memory entry.
// The capacity register sits at APB address 0; writing it clears both
// indices and the fill count but leaves the stored bytes in place.
// After reset all min(DEPTH, 511) byte memory entries are swept to zero,
// one entry per cycle, with s_tready low; APB writes are taken meanwhile.
// When the receiver stalls, the output register and one in-flight stage
// fill up and s_tready drops until m_tready returns.
module byte_ring_buffer_with_overwrite import brb_pkg::*; #(
    parameter int DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // data_byte[7:0], new_value[16:8], zero pad
    input  logic [2:0]  s_tuser,   // kind[2:0]
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // read_byte[7:0], read_position[15:8],
                                   // fill_level[24:16], zero pad
    output logic [2:0]  m_tuser    // status[2:0]
);

    mem_req_t         req;
    result_t          res;
    logic [IDX_W-1:0] capacity;
    logic [7:0]       rdata;
    logic             clr_busy;
    logic             cfg_wr;
    logic             s_accept;
    logic             p1_adv;

    logic             p1_valid_reg, p1_valid_next;
    result_t          p1_res_reg;
    logic             m_valid_reg, m_valid_next;
    logic [31:0]      m_data_reg;
    logic [2:0]       m_user_reg;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata = (paddr[2] == 1'b0) ? {23'b0, capacity} : 32'b0;

    assign p1_adv   = !m_valid_reg || m_tready;
    assign s_tready = !clr_busy && (!p1_valid_reg || p1_adv);
    assign s_accept = s_tvalid && s_tready;

    brb_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr    (cfg_wr),
        .cfg_cap   (pwdata[8:0]),
        .op_valid  (s_accept),
        .kind      (s_tuser),
        .data_byte (s_tdata[7:0]),
        .new_value (s_tdata[16:8]),
        .req       (req),
        .res       (res),
        .capacity  (capacity)
    );

    brb_mem #(.DEPTH(DEPTH)) u_mem (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (req),
        .rdata    (rdata),
        .clr_busy (clr_busy)
    );

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (s_accept) begin
            p1_valid_next = 1'b1;
        end else if (p1_adv) begin
            p1_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (p1_adv) begin
            m_valid_next = p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // memory read data lines up with the item held in the first stage
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_res_reg <= res;
        end
        if (p1_valid_reg && p1_adv) begin
            m_data_reg <= {7'b0, p1_res_reg.fill, p1_res_reg.position,
                           p1_res_reg.has_byte ? rdata : 8'h00};
            m_user_reg <= p1_res_reg.status;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
